/* design/decimating_fir_filter_assert.svh */
// assertion macros shared by the checker
`ifndef DECIMATING_FIR_FILTER_ASSERT_SVH
`define DECIMATING_FIR_FILTER_ASSERT_SVH

// same-cycle implication, off while in reset
`define DFIR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("decimating fir check failed");

// next-cycle implication, off while in reset
`define DFIR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("decimating fir check failed");

// what must hold in the cycle after a reset cycle
`define DFIR_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("decimating fir reset check failed");

`endif

/* design/dfir_pkg.sv */
`default_nettype none

package dfir_pkg;

    localparam int MAX_TAPS     = 256;
    localparam int MAX_COEFS    = 256;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 24;
    localparam int OUT_WIDTH    = 24;

    localparam int TAP_AW    = $clog2(MAX_TAPS);
    localparam int COEF_AW   = $clog2(MAX_COEFS);
    localparam int LEN_W     = 9;
    localparam int DECIM_W   = 9;
    localparam int FILL_W    = 10;
    localparam int SCALE_W   = 32;
    localparam int SHIFT_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int CNT_W      = LEN_W;
    localparam int WRAP_STEPS = LEN_W;
    localparam int DVS_W      = LEN_W + TAP_AW;
    localparam int MPROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W      = MPROD_W + TAP_AW;
    localparam int MUL_W      = 32;
    localparam int MULP_W     = MUL_W + SCALE_W;
    localparam int PROD_W     = ACC_W + SCALE_W;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_PHASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT   = 3'd4;

    localparam logic [LEN_W-1:0]   RST_TAP_COUNT  = 9'd256;
    localparam logic [DECIM_W-1:0] RST_DECIMATION = 9'd1;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 32'd65536;
    localparam logic [SHIFT_W-1:0] RST_SHIFT      = 6'd16;

    localparam logic [OUT_WIDTH-1:0] OUT_POS_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] OUT_NEG_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                     command;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [COEF_AW-1:0]             coef_index;
        logic signed [COEF_WIDTH-1:0]   coefficient;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] filtered;
        logic                        saturated;
    } t_out_item;

    typedef struct packed {
        logic              take;
        logic              wrap_step;
        logic              mac_clr;
        logic              mac_issue;
        logic [TAP_AW-1:0] tap_idx;
        logic              abs_load;
        logic              mul_lo;
        logic              mul_hi;
        logic              sum_load;
        logic              shf_load;
        logic              rnd_load;
        logic              emit;
    } t_dp_cmd;

    typedef struct packed {
        logic             is_sample;
        logic             hit;
        logic [LEN_W-1:0] tap_total;
        logic             pipe_busy;
        logic             out_free;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/dfir_ctrl.sv */
`default_nettype none

module dfir_ctrl
    import dfir_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_WRAP  = 11'b000_0000_0010,
        S_MAC   = 11'b000_0000_0100,
        S_DRAIN = 11'b000_0000_1000,
        S_ABS   = 11'b000_0001_0000,
        S_MULL  = 11'b000_0010_0000,
        S_MULH  = 11'b000_0100_0000,
        S_SUM   = 11'b000_1000_0000,
        S_SHF   = 11'b001_0000_0000,
        S_RND   = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] cnt_inc;

    assign cnt_inc = r_cnt + CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                n_cnt      = '0;
                if (i_in_valid && i_status.is_sample) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                // restoring remainder of the next write position, one bit per step
                o_cmd.wrap_step = 1'b1;
                o_cmd.mac_clr   = 1'b1;
                n_cnt           = cnt_inc;
                if (r_cnt == CNT_W'(WRAP_STEPS - 1)) begin
                    n_cnt = '0;
                    if (!i_status.hit) begin
                        n_state = S_IDLE;
                    end else if (i_status.tap_total == '0) begin
                        n_state = S_ABS;
                    end else begin
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.tap_idx   = r_cnt[TAP_AW-1:0];
                n_cnt           = cnt_inc;
                if (cnt_inc == i_status.tap_total) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                o_cmd.abs_load = 1'b1;
                n_state        = S_MULL;
            end
            S_MULL: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MULH;
            end
            S_MULH: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_load = 1'b1;
                n_state        = S_SHF;
            end
            S_SHF: begin
                o_cmd.shf_load = 1'b1;
                n_state        = S_RND;
            end
            S_RND: begin
                o_cmd.rnd_load = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* design/dfir_dp.sv */
`default_nettype none

module dfir_dp
    import dfir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    // configuration
    logic [LEN_W-1:0]   r_tap_count;
    logic [DECIM_W-1:0] r_decimation;
    logic               r_min_phase;
    logic [SCALE_W-1:0] r_scale;
    logic [SHIFT_W-1:0] r_shift;

    // ring position and fill
    logic [TAP_AW-1:0] r_wp;
    logic [FILL_W-1:0] r_fill;
    logic              r_hit;
    logic [LEN_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    // stores
    logic signed [SAMPLE_WIDTH-1:0] ring  [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]   coefs [MAX_COEFS];

    // mac pipeline
    logic                           r_rd_vld, r_prod_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_smp_q;
    logic signed [COEF_WIDTH-1:0]   r_coef_q;
    logic signed [MPROD_W-1:0]      r_mprod;
    logic signed [ACC_W-1:0]        r_acc;

    // scaling
    logic              r_neg;
    logic [ACC_W-1:0]  r_mag;
    logic [MULP_W-1:0] r_p0, r_p1;
    logic [PROD_W-1:0] r_big;
    logic              r_sticky;

    // output register
    logic      r_out_vld;
    t_out_item r_out;

    logic [LEN_W-1:0]   len, tap_total, half;
    logic [LEN_W-1:0]   wp_inc;
    logic [FILL_W-1:0]  fill_inc;
    logic               fill_hit;
    logic [LEN_W-1:0]   n_rem;
    logic [LEN_W-1:0]   addr_sum, addr_wrap, tap_ext, mirror;
    logic [TAP_AW-1:0]  smp_addr;
    logic [COEF_AW-1:0] coef_addr;
    logic               take_sample, take_load, take_clear;
    logic [MUL_W-1:0]   mul_a;
    logic [MULP_W-1:0]  mul_p;
    logic [ACC_W-1:0]   acc_mag;
    logic [PROD_W-1:0]  shift_mask;
    logic               sat;
    logic [OUT_WIDTH-1:0] res;

    assign take_sample = i_cmd.take && (i_in_item.command == CMD_SAMPLE);
    assign take_load   = i_cmd.take && (i_in_item.command == CMD_LOAD);
    assign take_clear  = i_cmd.take && (i_in_item.command == CMD_CLEAR);

    always_comb begin
        if (r_tap_count == '0) begin
            len = LEN_W'(1);
        end else if (r_tap_count > LEN_W'(MAX_TAPS)) begin
            len = LEN_W'(MAX_TAPS);
        end else begin
            len = r_tap_count;
        end
    end

    // symmetric mode folds len/2 coefficients over the oldest 2*(len/2) samples
    assign half      = {1'b0, len[LEN_W-1:1]};
    assign tap_total = r_min_phase ? len : {len[LEN_W-1:1], 1'b0};

    assign wp_inc   = {1'b0, r_wp} + LEN_W'(1);
    assign fill_inc = r_fill + FILL_W'(1);
    assign fill_hit = (fill_inc == FILL_W'(len));

    assign n_rem = ({{TAP_AW{1'b0}}, r_rem} >= r_dvs) ? (r_rem - r_dvs[LEN_W-1:0]) : r_rem;

    // tap addressing: the ring position is already below len here
    assign tap_ext   = {1'b0, i_cmd.tap_idx};
    assign addr_sum  = {1'b0, r_wp} + tap_ext;
    assign addr_wrap = addr_sum - len;
    assign smp_addr  = (addr_sum >= len) ? addr_wrap[TAP_AW-1:0] : addr_sum[TAP_AW-1:0];
    assign mirror    = tap_total - LEN_W'(1) - tap_ext;
    assign coef_addr = (r_min_phase || (tap_ext < half)) ? COEF_AW'(i_cmd.tap_idx)
                                                         : mirror[COEF_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= RST_TAP_COUNT;
            r_decimation <= RST_DECIMATION;
            r_min_phase  <= 1'b0;
            r_scale      <= RST_SCALE;
            r_shift      <= RST_SHIFT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TAP_COUNT:     r_tap_count  <= i_cfg_data[LEN_W-1:0];
                CFG_DECIMATION:    r_decimation <= i_cfg_data[DECIM_W-1:0];
                CFG_MINIMUM_PHASE: r_min_phase  <= i_cfg_data[0];
                CFG_OUTPUT_SCALE:  r_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_SHIFT:   r_shift      <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_hit  <= 1'b0;
        end else if (take_clear) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (take_sample) begin
            r_hit  <= fill_hit;
            r_fill <= fill_hit ? (fill_inc - FILL_W'(r_decimation)) : fill_inc;
        end else if (i_cmd.wrap_step) begin
            r_wp <= n_rem[TAP_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            r_rem <= wp_inc;
            r_dvs <= {len, {TAP_AW{1'b0}}};
        end else if (i_cmd.wrap_step) begin
            r_rem <= n_rem;
            r_dvs <= r_dvs >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            ring[r_wp] <= i_in_item.sample;
        end
        if (i_cmd.mac_issue) begin
            r_smp_q <= ring[smp_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_load) begin
            coefs[i_in_item.coef_index] <= i_in_item.coefficient;
        end
        if (i_cmd.mac_issue) begin
            r_coef_q <= coefs[coef_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.mac_issue;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_mprod <= r_smp_q * r_coef_q;
        end
        if (i_cmd.mac_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(ACC_W-MPROD_W){r_mprod[MPROD_W-1]}}, r_mprod};
        end
    end

    // magnitude times scale, split in two halves through one multiplier
    assign acc_mag = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;
    assign mul_a   = i_cmd.mul_hi ? MUL_W'(r_mag[ACC_W-1:MUL_W]) : r_mag[MUL_W-1:0];
    assign mul_p   = MULP_W'(mul_a) * MULP_W'(r_scale);
    assign shift_mask = ~({PROD_W{1'b1}} << r_shift);

    always_ff @(posedge i_clk) begin
        if (i_cmd.abs_load) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= acc_mag;
        end
        if (i_cmd.mul_lo) begin
            r_p0 <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_p1 <= mul_p;
        end
        if (i_cmd.sum_load) begin
            r_big <= PROD_W'(r_p0) + {r_p1[PROD_W-MUL_W-1:0], {MUL_W{1'b0}}};
        end else if (i_cmd.shf_load) begin
            r_big    <= r_big >> r_shift;
            r_sticky <= |(r_big & shift_mask);
        end else if (i_cmd.rnd_load) begin
            // negative values floor, so a lost fraction grows the magnitude
            r_big <= r_big + PROD_W'(r_neg & r_sticky);
        end
    end

    always_comb begin
        if (!r_neg) begin
            sat = (r_big > PROD_W'(OUT_POS_MAX));
            res = sat ? OUT_POS_MAX : r_big[OUT_WIDTH-1:0];
        end else begin
            sat = (r_big > PROD_W'(OUT_NEG_MIN));
            res = sat ? OUT_NEG_MIN : (OUT_WIDTH'(0) - r_big[OUT_WIDTH-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.filtered  <= res;
            r_out.saturated <= sat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    assign o_status.is_sample = (i_in_item.command == CMD_SAMPLE);
    assign o_status.hit       = r_hit;
    assign o_status.tap_total = tap_total;
    assign o_status.pipe_busy = r_rd_vld || r_prod_vld;
    assign o_status.out_free  = !r_out_vld || i_out_ready;

endmodule

`default_nettype wire

/* design/decimating_fir_filter.sv */
// Decimating FIR filter over a ring of the last tap_count samples (up to 256), with
// full or folded symmetric coefficient sets, a 32-bit scale and shift after the sum,
// and saturation to signed 24 bits. Coefficient loads and position resets finish as
// they are accepted. A sample is accepted and then the write position is brought
// back into the ring with a bit-serial remainder. A sample that completes a
// decimation period then runs T taps through one shared 24x24 multiply-accumulate,
// T being the ring length in minimum-phase mode and its even part in symmetric mode,
// followed by the pipeline drain and the two-pass 32-bit scale multiply. The result
// sits in an output register, so new items are taken while it waits. Configuration
// is always ready and is meant to be written only while the filter is idle.
`default_nettype none

module decimating_fir_filter
    import dfir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    dfir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    dfir_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* design/dfir_checker.sv */
`default_nettype none
`include "decimating_fir_filter_assert.svh"

module dfir_checker
    import dfir_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    `DFIR_ASSERT_RST(a_rst_no_out, !o_out_valid)

    `DFIR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // the filter only goes busy on a sample item
    `DFIR_ASSERT_IMP(a_busy_on_sample, $fell(o_in_ready), $past(i_in_valid) && ($past(i_in_item.command) == CMD_SAMPLE))

    // a new result appears only at the end of a busy stretch
    `DFIR_ASSERT_IMP(a_out_from_busy, $rose(o_out_valid), !$past(o_in_ready))

    `DFIR_ASSERT_IMP(a_sat_value, o_out_valid && o_out_item.saturated, (o_out_item.filtered == OUT_POS_MAX) || (o_out_item.filtered == OUT_NEG_MIN))

endmodule

bind decimating_fir_filter dfir_checker u_dfir_checker (.*);

`default_nettype wire

/* sim/decimating_fir_filter_test.sv */
`default_nettype none

module decimating_fir_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dfir_pkg::*;

    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam int FILL_MOD    = 4 * MAX_TAPS;
    localparam int SETTLE      = 300;
    localparam int QUIET_LIMIT = 5000;
    localparam int SHOWN       = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // filter state as the block should hold it
    logic signed [SAMPLE_WIDTH-1:0] ring_words [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]   coef_words [MAX_COEFS];
    int                ring_pos = 0;
    int                fill_level = 0;
    logic [LEN_W-1:0]   reg_taps = RST_TAP_COUNT;
    logic [DECIM_W-1:0] reg_decim = RST_DECIMATION;
    logic               reg_min_phase = 1'b0;
    logic [SCALE_W-1:0] reg_scale = RST_SCALE;
    logic [SHIFT_W-1:0] reg_shift = RST_SHIFT;

    t_in_item  items_to_send [$];
    t_out_item outputs_due [$];
    t_out_item want_item;

    logic steady = 1'b0;
    int   errors = 0;
    int   quiet_cycles = 0;
    int   n_samples = 0, n_loads = 0, n_clears = 0, n_ignored = 0;
    int   n_outputs = 0, n_clipped = 0, n_writes = 0;

    decimating_fir_filter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int ring_len();
        if (reg_taps == 0) begin
            return 1;
        end
        if (reg_taps > MAX_TAPS) begin
            return MAX_TAPS;
        end
        return int'(reg_taps);
    endfunction

    // correlation of the ring, oldest first, then scale, shift and clip
    function automatic t_out_item filter_point();
        int          len, half, i;
        longint      acc;
        logic [95:0] mag, prod, q;
        logic        neg, rem, clip;
        t_out_item   r;
        len = ring_len();
        acc = 0;
        if (reg_min_phase) begin
            for (i = 0; i < len; i++) begin
                acc += longint'(ring_words[(ring_pos + i) % len]) * longint'(coef_words[i]);
            end
        end else begin
            half = len / 2;
            for (i = 0; i < half; i++) begin
                acc += longint'(ring_words[(ring_pos + i) % len]) * longint'(coef_words[i]);
            end
            for (i = 0; i < half; i++) begin
                acc += longint'(ring_words[(ring_pos + half + i) % len])
                       * longint'(coef_words[half - 1 - i]);
            end
        end
        neg  = acc < 0;
        mag  = neg ? 96'(-acc) : 96'(acc);
        prod = mag * {64'd0, reg_scale};
        q    = prod >> reg_shift;
        rem  = (prod & ((96'd1 << reg_shift) - 96'd1)) != 96'd0;
        // arithmetic shift rounds toward minus infinity
        if (neg && rem) begin
            q = q + 96'd1;
        end
        if (!neg) begin
            clip = q > 96'd8388607;
            r.filtered = clip ? OUT_POS_MAX : q[23:0];
        end else begin
            clip = q > 96'd8388608;
            r.filtered = clip ? OUT_NEG_MIN : 24'd0 - q[23:0];
        end
        r.saturated = clip;
        return r;
    endfunction

    task automatic take_item(input t_in_item it);
        int len;
        case (it.command)
            CMD_LOAD: begin
                coef_words[it.coef_index] = it.coefficient;
                n_loads++;
            end
            CMD_CLEAR: begin
                ring_pos   = 0;
                fill_level = 0;
                n_clears++;
            end
            CMD_SAMPLE: begin
                len = ring_len();
                ring_words[ring_pos] = it.sample;
                ring_pos   = (ring_pos + 1) % len;
                fill_level = (fill_level + 1) % FILL_MOD;
                n_samples++;
                if (fill_level == len) begin
                    outputs_due.push_back(filter_point());
                    fill_level = (fill_level + FILL_MOD - int'(reg_decim)) % FILL_MOD;
                end
            end
            default: n_ignored++;
        endcase
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                take_item(in_item);
            end
            if (!in_valid || in_ready) begin
                if (items_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 18)) begin
                    in_valid <= 1'b1;
                    in_item  <= items_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (outputs_due.size() == 0) begin
                    errors++;
                    if (errors <= SHOWN) begin
                        $display("output with none pending: filtered %0d saturated %b",
                                 out_item.filtered, out_item.saturated);
                    end
                end else begin
                    want_item = outputs_due.pop_front();
                    n_outputs++;
                    if (want_item.saturated) begin
                        n_clipped++;
                    end
                    if (out_item.filtered !== want_item.filtered
                            || out_item.saturated !== want_item.saturated) begin
                        errors++;
                        if (errors <= SHOWN) begin
                            $display("output %0d: expected filtered %0d saturated %b, got %0d %b",
                                     n_outputs, want_item.filtered, want_item.saturated,
                                     out_item.filtered, out_item.saturated);
                        end
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no handshake for %0d cycles", QUIET_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // random signed word of random magnitude, extremes now and then
    function automatic logic [23:0] rand_word();
        int          w;
        logic [31:0] v, mask;
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: begin
                w    = $urandom_range(1, 24);
                mask = (32'd1 << w) - 32'd1;
                v    = $urandom & mask;
                if (v[w-1]) begin
                    v = v | ~mask;
                end
                return v[23:0];
            end
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [1:0] cmd, input logic [23:0] value,
                                           input logic [7:0] idx);
        t_in_item it;
        it.command     = cmd;
        it.sample      = rand_word();
        it.coef_index  = $urandom_range(0, 255);
        it.coefficient = rand_word();
        if (cmd == CMD_SAMPLE) begin
            it.sample = value;
        end else if (cmd == CMD_LOAD) begin
            it.coefficient = value;
            it.coef_index  = idx;
        end
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_TAP_COUNT:     reg_taps      = data[LEN_W-1:0];
            CFG_DECIMATION:    reg_decim     = data[DECIM_W-1:0];
            CFG_MINIMUM_PHASE: reg_min_phase = data[0];
            CFG_OUTPUT_SCALE:  reg_scale     = data[SCALE_W-1:0];
            CFG_SCALE_SHIFT:   reg_shift     = data[SHIFT_W-1:0];
            default: ;
        endcase
        n_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input int taps, input int decim, input int min_phase,
                            input logic [31:0] scale, input int shift);
        write_reg(CFG_TAP_COUNT, 32'(taps));
        write_reg(CFG_DECIMATION, 32'(decim));
        write_reg(CFG_MINIMUM_PHASE, 32'(min_phase));
        write_reg(CFG_OUTPUT_SCALE, scale);
        write_reg(CFG_SCALE_SHIFT, 32'(shift));
    endtask

    task automatic wait_idle();
        while (items_to_send.size() != 0 || in_valid || outputs_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin
        int          p, i, n, r, len, taps, decim, shift;
        logic [31:0] scale;
        logic [1:0]  cmd;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the low half of the coefficients and fill the whole ring; the full
        // symmetric ring reads only that half, and later settings never see enough
        // samples between clears to fill a longer ring; decimation above the ring
        // length leaves the fill count behind the write position
        write_reg(CFG_DECIMATION, 32'd300);
        for (i = 0; i < MAX_COEFS / 2; i++) begin
            items_to_send.push_back(make_item(CMD_LOAD, rand_word(), 8'(i)));
        end
        for (i = 0; i < MAX_TAPS; i++) begin
            items_to_send.push_back(make_item(CMD_SAMPLE, rand_word(), 8'd0));
        end
        wait_idle();

        // shorter ring while the fill count lies past it, no clear first
        set_mode(8, 1, 1, 32'd1, 0);
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'h7FFFFF, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'h800000, 8'd0));
        items_to_send.push_back(make_item(CMD_LOAD, 24'h7FFFFF, 8'd0));
        items_to_send.push_back(make_item(CMD_LOAD, 24'h800000, 8'd255));
        items_to_send.push_back(make_item(CMD_LOAD, 24'hFFFFFF, 8'd1));
        items_to_send.push_back(make_item(CMD_IGNORED, 24'd0, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'd0, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'hFFFFFF, 8'd0));
        items_to_send.push_back(make_item(CMD_CLEAR, 24'd0, 8'd0));
        for (i = 0; i < 8; i++) begin
            items_to_send.push_back(make_item(CMD_SAMPLE, i[0] ? 24'h800000 : 24'h7FFFFF, 8'd0));
        end
        wait_idle();

        // odd length in symmetric mode drops the newest sample
        set_mode(5, 2, 0, 32'hFFFFFFFF, 63);
        items_to_send.push_back(make_item(CMD_CLEAR, 24'd0, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'd1, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'hFFFFFF, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'h7FFFFF, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'h800000, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'h7FFFFF, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'h800000, 8'd0));
        items_to_send.push_back(make_item(CMD_SAMPLE, 24'h000123, 8'd0));
        wait_idle();

        for (p = 0; p < 12; p++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: taps = $urandom_range(1, 16);
                5:             taps = $urandom_range(17, 256);
                6:             taps = 256;
                7:             taps = 1;
                8:             taps = 0;
                default:       taps = $urandom_range(257, 511);
            endcase
            case (p)
                0: taps = 1;
                1: taps = 0;
                2: taps = 511;
                4: taps = 256;
                default: ;
            endcase
            len = (taps == 0) ? 1 : (taps > MAX_TAPS ? MAX_TAPS : taps);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: decim = $urandom_range(1, len);
                6:                decim = 1;
                7:                decim = 0;
                8:                decim = $urandom_range(len + 1, 511);
                default:          decim = 511;
            endcase
            if (p == 3) begin
                decim = 0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    scale = $urandom;
                    shift = $urandom_range(44, 63);
                end
                6: begin
                    scale = 32'd0;
                    shift = $urandom_range(0, 63);
                end
                7: begin
                    scale = 32'hFFFFFFFF;
                    shift = 0;
                end
                8: begin
                    scale = 32'd65536;
                    shift = 16;
                end
                default: begin
                    scale = $urandom;
                    shift = $urandom_range(0, 63);
                end
            endcase
            set_mode(taps, decim, $urandom_range(0, 1), scale, shift);
            steady = (p >= 6 && p <= 8);
            // every fourth setting keeps the old position and count
            if (p % 4 != 1) begin
                items_to_send.push_back(make_item(CMD_CLEAR, 24'd0, 8'd0));
            end
            n = $urandom_range(8, 16);
            for (i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                cmd = (r < 78) ? CMD_SAMPLE : (r < 88) ? CMD_LOAD : (r < 94) ? CMD_CLEAR
                                                                           : CMD_IGNORED;
                items_to_send.push_back(make_item(cmd, rand_word(), 8'($urandom_range(0, 255))));
            end
            wait_idle();
        end

        errors += outputs_due.size();
        $display("sent %0d samples, %0d coefficient loads, %0d clears, %0d ignored items",
                 n_samples, n_loads, n_clears, n_ignored);
        $display("over %0d register writes; %0d filter outputs checked, %0d of them clipped",
                 n_writes, n_outputs, n_clipped);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
